FILE: rtl/core/bank_switched_ram_card_defines.svh
// Assertion macros shared by the checker of the bank-switched RAM card.
// Depends on nothing; each macro expands to one labeled concurrent assertion.
`ifndef BANK_SWITCHED_RAM_CARD_DEFINES_SVH
`define BANK_SWITCHED_RAM_CARD_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BSRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bank switched RAM card: implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BSRC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bank switched RAM card: next-cycle check failed");

`endif

FILE: rtl/core/bsrc_pkg.sv
// Package of the bank-switched RAM card: sizes, item types and shared structs.
// Depends on nothing; bsrc_decode, the top level and the checker refer to it by scoped names.
package bsrc_pkg;

  localparam int ADDR_W      = 14;
  localparam int DATA_W      = 8;
  localparam int BANK_BYTES  = 4096;
  localparam int UPPER_BYTES = 8192;
  localparam int BANK_DEPTH  = 2 * BANK_BYTES;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int UPPER_AW    = $clog2(UPPER_BYTES);
  localparam int CLR_DEPTH   = (BANK_DEPTH > UPPER_BYTES) ? BANK_DEPTH : UPPER_BYTES;
  localparam int CLR_W       = $clog2(CLR_DEPTH + 1);
  localparam int ODD_W       = 2;
  localparam logic [ODD_W-1:0] ODD_SAT = ODD_W'(2);

  localparam logic ACT_SWITCH = 1'b0;

  typedef struct packed {
    logic              action;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] data;
    logic              is_write;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              inhibit_rom;
    logic              read_on;
    logic              write_on;
    logic              bank_sel;
  } out_item_t;

  typedef struct packed {
    logic read_on;
    logic write_on;
    logic bank_sel;
  } mode_t;

  typedef struct packed {
    logic                bank_we;
    logic                bank_re;
    logic                upper_we;
    logic                upper_re;
    logic [BANK_AW-1:0]  bank_idx;
    logic [UPPER_AW-1:0] upper_idx;
    logic [DATA_W-1:0]   wdata;
  } mem_req_t;

  typedef enum logic {
    CLR_SWEEP,
    CLR_READY
  } clr_state_t;

endpackage

FILE: rtl/core/bsrc_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is issued. No dependencies.
module bsrc_ram #(
  parameter int DEPTH = 8192,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/bsrc_decode.sv
// Soft-switch registers and window decode of the bank-switched RAM card.
// Depends on bsrc_pkg; issues the RAM request, if any, for each accepted window item.
module bsrc_decode (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  bsrc_pkg::in_item_t item,
  output bsrc_pkg::mem_req_t req,
  output bsrc_pkg::mode_t    mode_post
);

  logic [bsrc_pkg::ODD_W-1:0]  cnt_r;
  logic [bsrc_pkg::ODD_W-1:0]  cnt_nxt;
  bsrc_pkg::mode_t             mode_r;
  bsrc_pkg::mode_t             mode_nxt;
  logic                        in_bank;
  logic                        in_upper;
  logic [bsrc_pkg::ADDR_W-1:0] upper_off;
  logic                        win;

  always_comb begin
    cnt_nxt  = cnt_r;
    mode_nxt = mode_r;
    if (accept && (item.action == bsrc_pkg::ACT_SWITCH)) begin
      if (item.address[0] && !item.is_write) begin
        cnt_nxt = (cnt_r == bsrc_pkg::ODD_SAT) ? cnt_r : cnt_r + 1'b1;
      end else begin
        cnt_nxt = '0;
      end
      if (cnt_nxt == bsrc_pkg::ODD_SAT) begin
        mode_nxt.write_on = 1'b1;
      end
      if (!item.address[0]) begin
        mode_nxt.write_on = 1'b0;
      end
      mode_nxt.read_on  = ~(item.address[1] ^ item.address[0]);
      mode_nxt.bank_sel = ~item.address[3];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r           <= '0;
      mode_r.read_on  <= 1'b0;
      mode_r.write_on <= 1'b1;
      mode_r.bank_sel <= 1'b1;
    end else begin
      cnt_r  <= cnt_nxt;
      mode_r <= mode_nxt;
    end
  end

  assign mode_post = mode_nxt;

  always_comb begin
    in_bank   = item.address < bsrc_pkg::ADDR_W'(bsrc_pkg::BANK_BYTES);
    upper_off = item.address - bsrc_pkg::ADDR_W'(bsrc_pkg::BANK_BYTES);
    in_upper  = !in_bank && (upper_off < bsrc_pkg::ADDR_W'(bsrc_pkg::UPPER_BYTES));
    win       = accept && (item.action != bsrc_pkg::ACT_SWITCH);

    req.bank_idx  = bsrc_pkg::BANK_AW'(item.address)
                  + (mode_r.bank_sel ? bsrc_pkg::BANK_AW'(bsrc_pkg::BANK_BYTES) : '0);
    req.upper_idx = bsrc_pkg::UPPER_AW'(upper_off);
    req.wdata     = item.data;
    req.bank_re   = win && in_bank && mode_r.read_on && !item.is_write;
    req.upper_re  = win && in_upper && mode_r.read_on && !item.is_write;
    req.bank_we   = win && in_bank && mode_r.write_on && item.is_write;
    req.upper_we  = win && in_upper && mode_r.write_on && item.is_write;
  end

endmodule

FILE: rtl/core/bank_switched_ram_card.sv
// Top level of the bank-switched RAM card: clearing sweep, RAMs and result stage.
// Depends on bsrc_pkg, bsrc_decode and bsrc_ram.
//
// After reset the card sweeps both RAMs to zero, one entry of each per cycle;
// in_ready stays low until the sweep ends. From then on one item is accepted
// per cycle whenever results are taken. Each item makes at most one
// synchronous RAM access; its result passes the registered RAM read, held
// with the stage-one registers, and then the output register.
// The soft-switch flags in a result are those after that item.
module bank_switched_ram_card (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bsrc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bsrc_pkg::out_item_t out_data
);

  bsrc_pkg::clr_state_t        clr_state_r;
  bsrc_pkg::clr_state_t        clr_state_nxt;
  logic [bsrc_pkg::CLR_W-1:0]  clr_cnt_r;
  logic [bsrc_pkg::CLR_W-1:0]  clr_cnt_nxt;
  logic                        clr_we;
  logic                        clr_done;

  logic                        accept;
  logic                        adv;
  bsrc_pkg::mem_req_t          req;
  bsrc_pkg::mode_t             mode_post;

  logic                        s1_valid_r;
  logic                        s1_valid_nxt;
  logic                        s1_bank_r;
  logic                        s1_upper_r;
  logic [bsrc_pkg::DATA_W-1:0] s1_data_r;
  bsrc_pkg::mode_t             s1_mode_r;

  logic                        out_valid_r;
  logic                        out_valid_nxt;
  bsrc_pkg::out_item_t         out_data_r;
  bsrc_pkg::out_item_t         out_data_nxt;

  logic                        bank_we;
  logic [bsrc_pkg::BANK_AW-1:0]  bank_waddr;
  logic [bsrc_pkg::DATA_W-1:0]   bank_wdata;
  logic [bsrc_pkg::DATA_W-1:0]   bank_rdata;
  logic                        upper_we;
  logic [bsrc_pkg::UPPER_AW-1:0] upper_waddr;
  logic [bsrc_pkg::DATA_W-1:0]   upper_wdata;
  logic [bsrc_pkg::DATA_W-1:0]   upper_rdata;

  always_comb begin
    clr_state_nxt = clr_state_r;
    clr_cnt_nxt   = clr_cnt_r;
    case (clr_state_r)
      bsrc_pkg::CLR_SWEEP: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == bsrc_pkg::CLR_W'(bsrc_pkg::CLR_DEPTH - 1)) begin
          clr_state_nxt = bsrc_pkg::CLR_READY;
        end
      end
      bsrc_pkg::CLR_READY: begin
        clr_state_nxt = bsrc_pkg::CLR_READY;
      end
      default: begin
        clr_state_nxt = bsrc_pkg::CLR_SWEEP;
      end
    endcase
  end

  always_comb begin
    clr_we   = 1'b0;
    clr_done = 1'b0;
    case (clr_state_r)
      bsrc_pkg::CLR_SWEEP: clr_we   = 1'b1;
      bsrc_pkg::CLR_READY: clr_done = 1'b1;
      default:             clr_we   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_state_r <= bsrc_pkg::CLR_SWEEP;
      clr_cnt_r   <= '0;
    end else begin
      clr_state_r <= clr_state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
    end
  end

  assign adv      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = clr_done && (!s1_valid_r || adv);
  assign accept   = in_valid && in_ready;

  bsrc_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .req       (req),
    .mode_post (mode_post)
  );

  always_comb begin
    if (clr_we) begin
      bank_we     = clr_cnt_r < bsrc_pkg::CLR_W'(bsrc_pkg::BANK_DEPTH);
      bank_waddr  = bsrc_pkg::BANK_AW'(clr_cnt_r);
      bank_wdata  = '0;
      upper_we    = clr_cnt_r < bsrc_pkg::CLR_W'(bsrc_pkg::UPPER_BYTES);
      upper_waddr = bsrc_pkg::UPPER_AW'(clr_cnt_r);
      upper_wdata = '0;
    end else begin
      bank_we     = req.bank_we;
      bank_waddr  = req.bank_idx;
      bank_wdata  = req.wdata;
      upper_we    = req.upper_we;
      upper_waddr = req.upper_idx;
      upper_wdata = req.wdata;
    end
  end

  bsrc_ram #(
    .DEPTH (bsrc_pkg::BANK_DEPTH),
    .WIDTH (bsrc_pkg::DATA_W)
  ) u_bank_ram (
    .clk   (clk),
    .we    (bank_we),
    .waddr (bank_waddr),
    .wdata (bank_wdata),
    .re    (req.bank_re),
    .raddr (req.bank_idx),
    .rdata (bank_rdata)
  );

  bsrc_ram #(
    .DEPTH (bsrc_pkg::UPPER_BYTES),
    .WIDTH (bsrc_pkg::DATA_W)
  ) u_upper_ram (
    .clk   (clk),
    .we    (upper_we),
    .waddr (upper_waddr),
    .wdata (upper_wdata),
    .re    (req.upper_re),
    .raddr (req.upper_idx),
    .rdata (upper_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_bank_r  <= req.bank_re;
      s1_upper_r <= req.upper_re;
      s1_data_r  <= (in_data.action == bsrc_pkg::ACT_SWITCH) ? in_data.data : '0;
      s1_mode_r  <= mode_post;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    out_data_nxt.read_data   = s1_bank_r  ? bank_rdata  :
                               s1_upper_r ? upper_rdata : s1_data_r;
    out_data_nxt.inhibit_rom = s1_bank_r || s1_upper_r;
    out_data_nxt.read_on     = s1_mode_r.read_on;
    out_data_nxt.write_on    = s1_mode_r.write_on;
    out_data_nxt.bank_sel    = s1_mode_r.bank_sel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/core/bsrc_checker.sv
// Port-level checker of the bank-switched RAM card and its bind to the top level.
// Depends on bsrc_pkg and the assertion macros in bank_switched_ram_card_defines.svh.
`include "bank_switched_ram_card_defines.svh"

module bsrc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input bsrc_pkg::out_item_t out_data
);

  // The clearing sweep holds off items right after reset.
  `BSRC_ASSERT_IMP(a_sweep_after_reset, clk, rst_n, $past(!rst_n), !in_ready)

  // Card RAM only drives the bus while reading is switched on.
  `BSRC_ASSERT_IMP(a_inhibit_needs_read, clk, rst_n, out_valid && out_data.inhibit_rom, out_data.read_on)

  // A result that appears on an empty output comes from an accepted item that passed the stage-one register.
  `BSRC_ASSERT_IMP(a_result_has_item, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

  // A stalled result holds.
  `BSRC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))

endmodule

bind bank_switched_ram_card bsrc_checker u_bsrc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

FILE: tb/sv/bank_switched_ram_card_test.sv
// Self-checking testbench of the bank-switched RAM card: directed and random bus accesses.
// Depends on bsrc_pkg and bank_switched_ram_card; a tracker class predicts every reply
// from its own copy of the soft switches and both RAMs.

class ram_card_tracker;
  bit [bsrc_pkg::ODD_W-1:0]    odd_reads;
  bit                          write_en;
  bit                          read_en;
  bit                          bank_hi;
  logic [bsrc_pkg::DATA_W-1:0] lower_mem [bsrc_pkg::BANK_DEPTH];
  logic [bsrc_pkg::DATA_W-1:0] upper_mem [bsrc_pkg::UPPER_BYTES];
  bsrc_pkg::out_item_t         pending_replies [$];
  int                          errors;

  function new();
    odd_reads = '0;
    write_en  = 1'b1;
    read_en   = 1'b0;
    bank_hi   = 1'b1;
    errors    = 0;
    foreach (lower_mem[i]) lower_mem[i] = '0;
    foreach (upper_mem[i]) upper_mem[i] = '0;
  endfunction

  function void note_access(bsrc_pkg::in_item_t it);
    bsrc_pkg::out_item_t reply;
    int                  offset;
    int                  idx;
    reply  = '0;
    offset = int'(it.address);
    if (it.action == bsrc_pkg::ACT_SWITCH) begin
      if (it.address[0] && !it.is_write) begin
        if (odd_reads < bsrc_pkg::ODD_SAT) odd_reads++;
      end else begin
        odd_reads = '0;
      end
      if (odd_reads >= bsrc_pkg::ODD_SAT) write_en = 1'b1;
      if (!it.address[0]) write_en = 1'b0;
      read_en = (it.address[1:0] == 2'b00) || (it.address[1:0] == 2'b11);
      bank_hi = !it.address[3];
      reply.read_data = it.data;
    end else if (offset < bsrc_pkg::BANK_BYTES) begin
      idx = (bank_hi ? bsrc_pkg::BANK_BYTES : 0) + offset;
      if (read_en && !it.is_write) begin
        reply.read_data   = lower_mem[idx];
        reply.inhibit_rom = 1'b1;
      end else if (write_en && it.is_write) begin
        lower_mem[idx] = it.data;
      end
    end else if (offset - bsrc_pkg::BANK_BYTES < bsrc_pkg::UPPER_BYTES) begin
      idx = offset - bsrc_pkg::BANK_BYTES;
      if (read_en && !it.is_write) begin
        reply.read_data   = upper_mem[idx];
        reply.inhibit_rom = 1'b1;
      end else if (write_en && it.is_write) begin
        upper_mem[idx] = it.data;
      end
    end
    reply.read_on  = read_en;
    reply.write_on = write_en;
    reply.bank_sel = bank_hi;
    pending_replies.insert(pending_replies.size(), reply);
  endfunction

  function void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  function void check_reply(bsrc_pkg::out_item_t got);
    bsrc_pkg::out_item_t want;
    if (pending_replies.size() == 0) begin
      $display("%0t: unexpected item, expected none, actual %h", $time, got);
      errors++;
      return;
    end
    want = pending_replies.pop_front();
    compare_field("read_data", want.read_data, got.read_data);
    compare_field("inhibit_rom", want.inhibit_rom, got.inhibit_rom);
    compare_field("read_on", want.read_on, got.read_on);
    compare_field("write_on", want.write_on, got.write_on);
    compare_field("bank_sel", want.bank_sel, got.bank_sel);
  endfunction

  function void close_out();
    while (pending_replies.size() != 0) begin
      $display("%0t: missing item, expected %h, actual none", $time, pending_replies.pop_front());
      errors++;
    end
  endfunction
endclass

module bank_switched_ram_card_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_WINDOW = 1'b1;
  localparam int   WINDOW_END = bsrc_pkg::BANK_BYTES + bsrc_pkg::UPPER_BYTES;
  localparam int   ADDR_MAX   = (1 << bsrc_pkg::ADDR_W) - 1;
  localparam int   ITEM_GOAL  = 700;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  bsrc_pkg::in_item_t  in_data;
  logic                out_valid;
  logic                out_ready;
  bsrc_pkg::out_item_t out_data;

  ram_card_tracker tracker;
  bit send_calm;
  bit take_calm;
  int accesses_sent;

  bank_switched_ram_card dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) tracker.note_access(in_data);
      if (out_valid && out_ready) tracker.check_reply(out_data);
    end
  end

  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic bsrc_pkg::in_item_t make_access(logic act, int addr, int data, logic wr);
    bsrc_pkg::in_item_t it;
    it.action   = act;
    it.address  = addr[bsrc_pkg::ADDR_W-1:0];
    it.data     = data[bsrc_pkg::DATA_W-1:0];
    it.is_write = wr;
    return it;
  endfunction

  task automatic send_access(bsrc_pkg::in_item_t it);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accesses_sent++;
  endtask

  task automatic take_replies();
    int stall;
    forever begin
      stall = draw_wait(take_calm);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  endtask

  function automatic int pick_window_offset();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 31);
      1:       return $urandom_range(bsrc_pkg::BANK_BYTES - 16, bsrc_pkg::BANK_BYTES + 15);
      2:       return $urandom_range(WINDOW_END - 32, WINDOW_END - 1);
      default: return $urandom_range(0, WINDOW_END - 1);
    endcase
  endfunction

  task automatic send_random_access();
    int choice;
    int addr;
    choice = $urandom_range(0, 99);
    if (choice < 20) begin
      addr = ($urandom_range(0, ADDR_MAX) & ~1) | 1;
      send_access(make_access(bsrc_pkg::ACT_SWITCH, addr, $urandom_range(0, 255), 1'b0));
      addr = ($urandom_range(0, ADDR_MAX) & ~1) | 1;
      send_access(make_access(bsrc_pkg::ACT_SWITCH, addr, $urandom_range(0, 255), 1'b0));
    end else if (choice < 35) begin
      send_access(make_access(bsrc_pkg::ACT_SWITCH, $urandom_range(0, ADDR_MAX),
                              $urandom_range(0, 255), 1'($urandom_range(0, 1))));
    end else if (choice < 92) begin
      send_access(make_access(ACT_WINDOW, pick_window_offset(),
                              $urandom_range(0, 255), 1'($urandom_range(0, 1))));
    end else begin
      send_access(make_access(ACT_WINDOW, $urandom_range(WINDOW_END, ADDR_MAX),
                              $urandom_range(0, 255), 1'($urandom_range(0, 1))));
    end
  endtask

  initial begin
    tracker       = new();
    send_calm     = 1'b0;
    take_calm     = 1'b0;
    accesses_sent = 0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    fork
      take_replies();
    join_none

    // Reset leaves bank one selected, writes on and reads off.
    send_access(make_access(ACT_WINDOW, 0, 8'hFF, 1'b1));
    send_access(make_access(ACT_WINDOW, WINDOW_END - 1, 8'hA5, 1'b1));
    send_access(make_access(ACT_WINDOW, 0, 8'h00, 1'b0));
    send_access(make_access(bsrc_pkg::ACT_SWITCH, 14'h0000, 8'h5A, 1'b0));
    send_access(make_access(ACT_WINDOW, 0, 8'h00, 1'b0));
    send_access(make_access(ACT_WINDOW, WINDOW_END - 1, 8'h00, 1'b0));
    send_access(make_access(ACT_WINDOW, 1, 8'h77, 1'b1));
    send_access(make_access(bsrc_pkg::ACT_SWITCH, 14'h000B, 8'h00, 1'b0));
    send_access(make_access(bsrc_pkg::ACT_SWITCH, 14'h000B, 8'hFF, 1'b0));
    send_access(make_access(ACT_WINDOW, 0, 8'h3C, 1'b1));
    send_access(make_access(ACT_WINDOW, 0, 8'h00, 1'b0));
    send_access(make_access(ACT_WINDOW, bsrc_pkg::BANK_BYTES - 1, 8'h81, 1'b1));
    send_access(make_access(ACT_WINDOW, bsrc_pkg::BANK_BYTES - 1, 8'h00, 1'b0));
    send_access(make_access(ACT_WINDOW, bsrc_pkg::BANK_BYTES, 8'h7E, 1'b1));
    send_access(make_access(ACT_WINDOW, bsrc_pkg::BANK_BYTES, 8'h00, 1'b0));
    send_access(make_access(ACT_WINDOW, WINDOW_END, 8'h99, 1'b1));
    send_access(make_access(ACT_WINDOW, ADDR_MAX, 8'h00, 1'b0));
    send_access(make_access(bsrc_pkg::ACT_SWITCH, 14'h0001, 8'h11, 1'b1));
    send_access(make_access(bsrc_pkg::ACT_SWITCH, 14'h0003, 8'hFF, 1'b0));
    send_access(make_access(bsrc_pkg::ACT_SWITCH, 14'h0002, 8'h22, 1'b1));
    send_access(make_access(bsrc_pkg::ACT_SWITCH, 14'h3FFF, 8'h33, 1'b0));
    send_access(make_access(bsrc_pkg::ACT_SWITCH, 14'h0009, 8'h44, 1'b0));
    send_access(make_access(ACT_WINDOW, 0, 8'h00, 1'b0));
    send_access(make_access(ACT_WINDOW, 2, 8'h55, 1'b1));
    send_access(make_access(bsrc_pkg::ACT_SWITCH, 14'h2FF8, 8'h80, 1'b0));

    while (accesses_sent < ITEM_GOAL) send_random_access();
    in_valid <= 1'b0;

    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    tracker.close_out();
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
